[rtl/rar_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rar_pkg: shared types and constants for the rational arithmetic unit
// Operation, status and form codes, the controller state type and the
// command and status bundles that pass between controller and datapath.
// ---------------------------------------------------------------------------
package rar_pkg;

   localparam int OperandWidthDefault = 16;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_DIV_ZERO = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FORM_INT   = 2'd0,
      FORM_FRAC  = 2'd1,
      FORM_MIXED = 2'd2
   } form_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_SUM,
      S_SIGN,
      S_GCD_INIT,
      S_GCD,
      S_RED_INIT,
      S_RED_NUM,
      S_RED_DEN,
      S_WHOLE_INIT,
      S_WHOLE,
      S_FINISH,
      S_OUT
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;        // capture operands
      logic mul;         // form cross products
      logic sum;         // combine products into numerator and denominator
      logic sign;        // normalize sign, check errors
      logic gcd_init;    // start gcd
      logic gcd_step;    // one remainder bit step
      logic red_init;    // start divide of numerator by gcd
      logic red_num_end; // keep quotient as numerator, start denominator divide
      logic div_step;    // one restoring-divide step
      logic red_den_end; // keep quotient as denominator
      logic whole_init;  // start divide of numerator by denominator
      logic finish;      // build result
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic error;       // zero denominator or division by zero
      logic gcd_done;    // gcd finished
      logic div_last;    // divider on its last step
      logic mixed;       // result needs whole part split
   } stat_type;

endpackage

`default_nettype wire

[rtl/rar_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rar_ctrl: sequencer for the rational arithmetic unit
// Walks one request through multiply, sign, gcd, reduce and split steps.
// ---------------------------------------------------------------------------
module rar_ctrl
   import rar_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  wire logic     rsp_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:       if (req_tvalid) state_in = S_MUL;
         S_MUL:        state_in = S_SUM;
         S_SUM:        state_in = S_SIGN;
         S_SIGN:       state_in = stat.error ? S_OUT : S_GCD_INIT;
         S_GCD_INIT:   state_in = S_GCD;
         S_GCD:        if (stat.gcd_done) state_in = S_RED_INIT;
         S_RED_INIT:   state_in = S_RED_NUM;
         S_RED_NUM:    if (stat.div_last) state_in = S_RED_DEN;
         S_RED_DEN:    if (stat.div_last) state_in = S_WHOLE_INIT;
         S_WHOLE_INIT: state_in = stat.mixed ? S_WHOLE : S_FINISH;
         S_WHOLE:      if (stat.div_last) state_in = S_FINISH;
         S_FINISH:     state_in = S_OUT;
         S_OUT:        if (rsp_tready) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_MUL:        cmd.mul = 1'b1;
         S_SUM:        cmd.sum = 1'b1;
         S_SIGN:       cmd.sign = 1'b1;
         S_GCD_INIT:   cmd.gcd_init = 1'b1;
         S_GCD:        cmd.gcd_step = 1'b1;
         S_RED_INIT:   cmd.red_init = 1'b1;
         S_RED_NUM: begin
            cmd.div_step    = 1'b1;
            cmd.red_num_end = stat.div_last;
         end
         S_RED_DEN: begin
            cmd.div_step    = 1'b1;
            cmd.red_den_end = stat.div_last;
         end
         S_WHOLE_INIT: cmd.whole_init = 1'b1;
         S_WHOLE:      cmd.div_step = 1'b1;
         S_FINISH:     cmd.finish = 1'b1;
         S_OUT:        rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

[rtl/rar_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rar_dp: datapath of the rational arithmetic unit
// Cross products, sign normalization, and one bit-serial restoring divider
// shared by the gcd remainder passes, reduction and whole-part split.
// ---------------------------------------------------------------------------
module rar_dp
   import rar_pkg::*;
#(
   parameter int OPERAND_WIDTH = OperandWidthDefault
) (
   input  wire logic                     clock,
   input  wire cmd_type                  cmd,
   output stat_type                      stat,
   input  wire logic [1:0]               op,
   input  wire logic [OPERAND_WIDTH-1:0] first_num,
   input  wire logic [OPERAND_WIDTH-1:0] first_den,
   input  wire logic [OPERAND_WIDTH-1:0] second_num,
   input  wire logic [OPERAND_WIDTH-1:0] second_den,
   output logic [1:0]                    status,
   output logic [1:0]                    form,
   output logic [31:0]                   whole_part,
   output logic [32:0]                   result_num,
   output logic [30:0]                   result_den
);

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * W;       // signed product width
   localparam int SW = PW + 1;      // signed sum width
   localparam int MW = PW;          // magnitude width
   localparam int CW = $clog2(MW + 1);

   logic [1:0]          op_ff;
   logic signed [W-1:0] a_ff, b_ff, c_ff, d_ff;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [SW-1:0] n_ff;
   logic signed [SW-1:0] m_ff;
   logic                 err_ff;
   logic [1:0]           err_code_ff;
   logic                 neg_ff;
   logic [MW-1:0]        mag_ff, den_ff;
   // gcd and divider share x (dividend/shift), y (divisor), r (remainder).
   logic [MW-1:0]        x_ff, y_ff, r_ff, q_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 gdone_ff;
   logic [1:0]           status_ff, form_ff;
   logic [31:0]          whole_ff;
   logic [32:0]          rnum_ff;
   logic [30:0]          rden_ff;

   logic signed [PW-1:0] pa, pb, pc;
   logic signed [SW-1:0] n_in, m_in;
   logic [MW:0]          r_sh, r_sub;
   logic [MW-1:0]        r_next, q_next;
   logic                 fits;
   logic [SW-1:0]        mag_in;

   always_comb begin
      r_sh   = {r_ff, x_ff[MW-1]};
      r_sub  = r_sh - {1'b0, y_ff};
      fits   = !r_sub[MW];
      r_next = fits ? r_sub[MW-1:0] : r_sh[MW-1:0];
      q_next = {q_ff[MW-2:0], fits};
   end

   always_comb begin
      unique case (op_type'(op_ff))
         OP_ADD, OP_SUB: begin
            pa = a_ff * d_ff; pb = b_ff * c_ff; pc = b_ff * d_ff;
         end
         OP_MUL: begin
            pa = a_ff * c_ff; pb = '0; pc = b_ff * d_ff;
         end
         default: begin
            pa = a_ff * d_ff; pb = '0; pc = b_ff * c_ff;
         end
      endcase
      if (op_type'(op_ff) == OP_SUB) begin
         n_in = SW'(p0_ff) - SW'(p1_ff);
      end else begin
         n_in = SW'(p0_ff) + SW'(p1_ff);
      end
      m_in = SW'(p2_ff);
   end

   always_comb begin
      if (n_ff[SW-1]) mag_in = -n_ff;
      else            mag_in = n_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= op;
         a_ff  <= first_num;  b_ff <= first_den;
         c_ff  <= second_num; d_ff <= second_den;
      end
      if (cmd.mul) begin
         p0_ff <= pa; p1_ff <= pb; p2_ff <= pc;
         err_ff      <= (b_ff == '0) || (d_ff == '0);
         err_code_ff <= ST_ZERO_DEN;
      end
      if (cmd.sum) begin
         n_ff <= n_in;
         m_ff <= m_in;
         if (!err_ff && m_in == '0) begin
            err_ff      <= 1'b1;
            err_code_ff <= ST_DIV_ZERO;
         end
      end
      if (cmd.sign) begin
         // Sign moves onto the numerator: negative iff signs differ.
         neg_ff <= (n_ff != '0) && (n_ff[SW-1] != m_ff[SW-1]);
         mag_ff <= MW'(mag_in);
         den_ff <= m_ff[SW-1] ? MW'(-m_ff) : MW'(m_ff);
         if (err_ff) begin
            status_ff <= err_code_ff;
            form_ff   <= FORM_INT;
            whole_ff  <= '0;
            rnum_ff   <= '0;
            rden_ff   <= 31'd1;
         end
      end
      // Gcd: x holds the dividend, y the divisor; each pass of MW bit steps
      // yields x mod y, then the pair rotates.
      if (cmd.gcd_init) begin
         x_ff     <= mag_ff;
         y_ff     <= den_ff;
         r_ff     <= '0;
         cnt_ff   <= '0;
         gdone_ff <= 1'b0;
      end
      if (cmd.gcd_step) begin
         if (cnt_ff == CW'(MW - 1)) begin
            if (r_next == '0) begin
               gdone_ff <= 1'b1;
               q_ff     <= y_ff;
            end else begin
               x_ff <= y_ff;
               y_ff <= r_next;
            end
            r_ff   <= '0;
            cnt_ff <= '0;
         end else begin
            x_ff   <= {x_ff[MW-2:0], 1'b0};
            r_ff   <= r_next;
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
      if (cmd.red_init) begin
         x_ff   <= mag_ff;
         y_ff   <= q_ff;
         r_ff   <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         x_ff   <= {x_ff[MW-2:0], 1'b0};
         r_ff   <= r_next;
         q_ff   <= q_next;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CW'(MW - 1)) cnt_ff <= '0;
      end
      if (cmd.red_num_end) begin
         mag_ff <= q_next;
         x_ff   <= den_ff;
         r_ff   <= '0;
         q_ff   <= y_ff;
         y_ff   <= y_ff;
      end
      if (cmd.red_den_end) begin
         den_ff <= (mag_ff == '0) ? MW'(1) : q_next;
      end
      if (cmd.whole_init) begin
         x_ff   <= mag_ff;
         y_ff   <= den_ff;
         r_ff   <= '0;
         cnt_ff <= '0;
      end
      if (cmd.finish) begin
         status_ff <= ST_OK;
         rden_ff   <= 31'(den_ff);
         if (den_ff == MW'(1)) begin
            form_ff  <= FORM_INT;
            whole_ff <= '0;
            rnum_ff  <= neg_ff ? -33'(mag_ff) : 33'(mag_ff);
            rden_ff  <= 31'd1;
         end else if (!neg_ff && mag_ff > den_ff) begin
            form_ff  <= FORM_MIXED;
            whole_ff <= 32'(q_ff);
            rnum_ff  <= 33'(r_ff);
         end else begin
            form_ff  <= FORM_FRAC;
            whole_ff <= '0;
            rnum_ff  <= neg_ff ? -33'(mag_ff) : 33'(mag_ff);
         end
      end
   end

   assign stat.error    = err_ff;
   assign stat.gcd_done = gdone_ff;
   assign stat.div_last = (cnt_ff == CW'(MW - 1));
   assign stat.mixed    = (den_ff != MW'(1)) && !neg_ff && (mag_ff > den_ff);

   assign status     = status_ff;
   assign form       = form_ff;
   assign whole_part = whole_ff;
   assign result_num = rnum_ff;
   assign result_den = rden_ff;

endmodule

`default_nettype wire

[rtl/rational_arith_reduce.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rational_arith_reduce: add, subtract, multiply or divide two fractions
// An input error skips the gcd, reduce and split steps; otherwise the gcd
// loop repeats remainder passes until a remainder is zero, then numerator
// and denominator are divided by the gcd, and a mixed number is split into
// its whole part. One request at a time; the next is accepted in the cycle
// after the result is taken at the earliest. Reset returns the sequencer to
// idle; no other state is reset.
// ---------------------------------------------------------------------------
module rational_arith_reduce
   import rar_pkg::*;
#(
   parameter int OPERAND_WIDTH = OperandWidthDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // op, first_num, first_den, second_num, second_den from bit 0 up
   input  wire logic [((2+4*OPERAND_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic       rsp_tvalid,
   input  wire logic  rsp_tready,
   // status, form, whole_part, result_num, result_den from bit 0 up
   output logic [103:0] rsp_tdata
);

   localparam int W = OPERAND_WIDTH;

   cmd_type  cmd;
   stat_type stat;
   logic [1:0]  status, form;
   logic [31:0] whole_part;
   logic [32:0] result_num;
   logic [30:0] result_den;

   rar_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .stat, .cmd
   );

   rar_dp #(.OPERAND_WIDTH(W)) u_dp (
      .clock, .cmd, .stat,
      .op         (req_tdata[1:0]),
      .first_num  (req_tdata[2+W-1:2]),
      .first_den  (req_tdata[2+2*W-1:2+W]),
      .second_num (req_tdata[2+3*W-1:2+2*W]),
      .second_den (req_tdata[2+4*W-1:2+3*W]),
      .status, .form, .whole_part, .result_num, .result_den
   );

   assign rsp_tdata = {4'd0, result_den, result_num, whole_part, form, status};

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for rational_arith_reduce
// Streams fraction requests through the block with random idling on both
// sides, predicts each reduced result and compares it field by field.
// ---------------------------------------------------------------------------
module testbench
   import rar_pkg::*;
();

   localparam int W = 16;
   localparam int REQ_BITS = ((2 + 4 * W + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 5000000;
   localparam int HOLD_CYCLES = 600;

   // Last member sits in the lowest bits, matching the result layout.
   typedef struct packed {
      logic [30:0] result_den;
      logic [32:0] result_num;
      logic [31:0] whole_part;
      logic [1:0]  form;
      logic [1:0]  status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;

   logic [REQ_BITS-1:0] pending_reqs[$];
   answer_type expected_answers[$];
   int send_idle_pct = 9;
   int recv_idle_pct = 48;
   bit long_stall = 1'b0;
   bit stall_done = 1'b0;
   int hold_count = 0;
   int errors = 0;
   int cycles = 0;
   logic req_tready_seen = 1'b0;

   rational_arith_reduce #(.OPERAND_WIDTH(W)) dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Exact arithmetic on the two fractions, reduced by their gcd.
   function automatic answer_type reduce_fraction(logic [REQ_BITS-1:0] r);
      answer_type ans;
      op_type op;
      longint a, b, c, d, n, m, x, y, t;
      longint unsigned mag, den;
      bit neg;
      op = op_type'(r[1:0]);
      a = $signed(r[2+:W]);
      b = $signed(r[2+W+:W]);
      c = $signed(r[2+2*W+:W]);
      d = $signed(r[2+3*W+:W]);
      ans = '{status: ST_OK, form: FORM_INT, whole_part: 32'd0,
              result_num: 33'd0, result_den: 31'd1};
      if (b == 0 || d == 0) begin
         ans.status = ST_ZERO_DEN;
         return ans;
      end
      case (op)
         OP_ADD: begin n = a * d + b * c; m = b * d; end
         OP_SUB: begin n = a * d - b * c; m = b * d; end
         OP_MUL: begin n = a * c; m = b * d; end
         default: begin n = a * d; m = b * c; end
      endcase
      if (m == 0) begin
         ans.status = ST_DIV_ZERO;
         return ans;
      end
      if (m < 0) begin
         m = -m;
         n = -n;
      end
      neg = n < 0;
      mag = neg ? -n : n;
      den = m;
      x = mag;
      y = den;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      mag = mag / x;
      den = den / x;
      if (mag == 0) den = 1;
      n = neg ? -longint'(mag) : longint'(mag);
      if (den == 1) begin
         ans.result_num = n[32:0];
      end else if (!neg && mag > den) begin
         ans.form = FORM_MIXED;
         ans.whole_part = 32'(mag / den);
         ans.result_num = 33'(mag % den);
         ans.result_den = 31'(den);
      end else begin
         ans.form = FORM_FRAC;
         ans.result_num = n[32:0];
         ans.result_den = 31'(den);
      end
      return ans;
   endfunction

   function automatic logic [REQ_BITS-1:0] pack_request(op_type op,
         logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c, logic [W-1:0] d);
      logic [REQ_BITS-1:0] r;
      r = '0;
      r[1:0] = op;
      r[2+:W] = a;
      r[2+W+:W] = b;
      r[2+2*W+:W] = c;
      r[2+3*W+:W] = d;
      return r;
   endfunction

   task automatic queue_request(logic [REQ_BITS-1:0] r);
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   // Half small magnitudes so results often reduce, with full range and extremes mixed in.
   function automatic logic [W-1:0] random_operand();
      case ($urandom_range(0, 3))
         0: return W'($urandom);
         1: return W'($urandom_range(0, 24) - 12);
         2: return W'($urandom_range(0, 400) - 200);
         default: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      endcase
   endfunction

   task automatic add_random(int count);
      op_type op;
      logic [W-1:0] dval;
      for (int i = 0; i < count; i++) begin
         op = op_type'($urandom_range(0, 3));
         dval = random_operand();
         if (dval == 0 && $urandom_range(0, 9) != 0) dval = 1;
         queue_request(pack_request(op, random_operand(), dval,
            random_operand(), $urandom_range(0, 15) == 0 ? 16'd0 : random_operand() | 16'd1));
      end
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_answers.size() != 0)
         @(posedge clock);
   endtask

   // Driver: a new request is offered at the falling edge after acceptance.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready_seen) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tdata <= pending_reqs.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random idling, and one long hold-off counted here.
   always @(negedge clock) begin
      if (!reset) begin
         if (long_stall && !stall_done) begin
            rsp_tready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1) stall_done <= 1'b1;
         end else begin
            rsp_tready <= $urandom_range(0, 99) >= recv_idle_pct;
         end
      end
   end

   // Monitor: requests and results are sampled at the rising edge.
   always @(posedge clock) begin
      answer_type got, want;
      cycles <= cycles + 1;
      req_tready_seen <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_answers.insert(expected_answers.size(), reduce_fraction(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(answer_type)-1:0];
            if (expected_answers.size() == 0) begin
               $display("%0t: result with none expected: %h", $time, got);
               errors <= errors + 1;
            end else begin
               want = expected_answers.pop_front();
               if (got.status !== want.status || got.form !== want.form ||
                     got.whole_part !== want.whole_part ||
                     got.result_num !== want.result_num ||
                     got.result_den !== want.result_den) begin
                  $display("%0t: mismatch expected %0d/%0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d/%0d",
                     $time, want.status, want.form, want.whole_part,
                     $signed(want.result_num), want.result_den, got.status, got.form,
                     got.whole_part, $signed(got.result_num), got.result_den);
                  errors <= errors + 1;
               end
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // Directed: every operation, field extremes, the error cases, zero,
      // negative improper and mixed results.
      for (int op = 0; op < 4; op++) begin
         queue_request(pack_request(op_type'(op), 16'h8000, 16'h8000,
            16'h7fff, 16'h7fff));
         queue_request(pack_request(op_type'(op), 16'h7fff, 16'h8001,
            16'h8000, 16'h0001));
      end
      queue_request(pack_request(OP_ADD, 16'd1, 16'd0, 16'd1, 16'd2));
      queue_request(pack_request(OP_DIV, 16'd1, 16'd2, 16'd3, 16'd0));
      queue_request(pack_request(OP_DIV, 16'd1, 16'd2, 16'd0, 16'd5));
      queue_request(pack_request(OP_SUB, 16'd3, 16'd4, 16'd3, 16'd4));
      queue_request(pack_request(OP_ADD, 16'd7, 16'd2, 16'd1, 16'd3));
      queue_request(pack_request(OP_ADD, -16'sd7, 16'd2, 16'd0, 16'd3));
      queue_request(pack_request(OP_MUL, 16'd6, -16'sd4, -16'sd2, 16'd3));
      queue_request(pack_request(OP_DIV, 16'd1, 16'd3, 16'd1, 16'd6));
      queue_request(pack_request(OP_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
      // Long receiver stall while requests keep coming.
      long_stall = 1'b1;
      wait_drained();
      add_random(200);
      wait_drained();
      send_idle_pct = 48;
      recv_idle_pct = 9;
      add_random(200);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random(200);
      wait_drained();
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
